FILE: src/mrwt_pkg.sv
// ----------------------------------------------------------------------------
// mrwt_pkg : shared constants for the Miller-Rabin witness test
// Holds the arithmetic width and the stream bus widths.
// ----------------------------------------------------------------------------
package mrwt_pkg;

    // width of the modular arithmetic (low bits of candidate and witness used)
    localparam int NUM_WIDTH  = 32;
    // width of each input number field on the bus
    localparam int FIELD_W    = 32;
    // counter width able to hold NUM_WIDTH itself
    localparam int CNT_W      = $clog2(NUM_WIDTH + 1);
    // stream bus data widths
    localparam int IN_DATA_W  = 2 * FIELD_W;
    localparam int OUT_DATA_W = 8;

endpackage

FILE: src/miller_rabin_witness_test.sv
// ----------------------------------------------------------------------------
// miller_rabin_witness_test : one Miller-Rabin round per input transfer
// Bit-serial modular reduction and shift-and-add modular multiplication,
// with a sticky composite flag collected over each run of witnesses.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                        Payload (lowest bit first)
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: candidate[31:0],
//                                                  witness[63:32];
//                                                  tlast: last_witness
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: verdict[0], zeros;
//                                                  tlast: run_done
//
//  All modular multiplications go through the single shared multiplier,
//  which handles each multiplier bit as a double, then a conditional add.
//  Even candidates, 0, 1 and 2 are settled in the check state alone.
//  One round is in work at a time; a new item is taken as soon as the block
//  is back in idle, even while the previous result waits on the output.
//  Reset is synchronous, active low, and clears the run flag and all valids.
//  A stalled output holds its result and keeps the finished round parked.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // candidate [31:0], witness [63:32]
    input  logic [mrwt_pkg::IN_DATA_W-1:0] i_s_axis_tdata,
    input  logic                           i_s_axis_tlast,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // verdict [0], zero fill [7:1]
    output logic [mrwt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                           o_m_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready
);

    localparam int W  = mrwt_pkg::NUM_WIDTH;
    localparam int CW = mrwt_pkg::CNT_W;
    localparam int FW = mrwt_pkg::FIELD_W;

    typedef enum logic [3:0] {
        S_IDLE,    // wait for an input transfer
        S_CHECK,   // settle the trivial candidates
        S_REDUCE,  // witness mod n, one bit a cycle
        S_FACTOR,  // strip trailing zeros of n-1
        S_POW,     // square-and-multiply control
        S_PMUL,    // acc * base running
        S_PSQR,    // base * base running
        S_TEST,    // first check of x
        S_SQ,      // squaring loop control
        S_SQW,     // x * x running
        S_DONE     // park the finding until the output frees up
    } t_state;

    // (x + y) mod n for x, y < n
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                             input logic [W-1:0] y,
                                             input logic [W-1:0] n);
        logic [W:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        if (sum >= {1'b0, n}) begin
            return W'(sum - {1'b0, n});
        end
        return W'(sum);
    endfunction

    t_state        r_state;
    logic [W-1:0]  r_cand;     // n
    logic [W-1:0]  r_wit;      // witness, shifted out MSB first during reduction
    logic          r_last;
    logic          r_comp;     // this round's finding
    logic          r_seen;     // sticky composite flag of the run
    logic [W-1:0]  r_rem;      // witness mod n
    logic [W-1:0]  r_exp;      // r, shifted right as it is consumed
    logic [CW-1:0] r_s;        // trailing zero count of n-1
    logic [CW-1:0] r_cnt;      // reduction bit count and squaring index
    logic [W-1:0]  r_acc;      // power accumulator, then x
    logic [W-1:0]  r_base;

    // shared modular multiplier
    logic          r_mbusy;
    logic          r_mph;      // 0: double, 1: conditional add
    logic [W-1:0]  r_mx;
    logic [W-1:0]  r_my;
    logic [W-1:0]  r_macc;
    logic [CW-1:0] r_mcnt;

    // output register
    logic          r_out_valid;
    logic          r_verdict;
    logic          r_run_done;

    logic [W-1:0]  cand_in;
    logic [W-1:0]  wit_in;
    logic [W-1:0]  m_sum;
    logic [W-1:0]  m_res;
    logic          m_last;
    logic [W:0]    red_t;
    logic [W-1:0]  red_next;
    logic [W-1:0]  n_minus1;
    logic          in_xfer;
    logic          out_free;

    assign cand_in  = W'(i_s_axis_tdata[FW-1:0]);
    assign wit_in   = W'(i_s_axis_tdata[2*FW-1:FW]);
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign n_minus1 = r_cand - W'(1);

    // one modular add serves both multiplier phases
    assign m_sum  = add_mod(r_macc, r_mph ? r_mx : r_macc, r_cand);
    assign m_res  = r_my[W-1] ? m_sum : r_macc;
    assign m_last = r_mbusy && r_mph && (r_mcnt == CW'(W - 1));

    // restoring reduction step: shift in the next witness bit
    assign red_t    = {r_rem, r_wit[W-1]};
    assign red_next = (red_t >= {1'b0, r_cand}) ? W'(red_t - {1'b0, r_cand}) : W'(red_t);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_run_done;
    assign o_m_axis_tdata  = {(mrwt_pkg::OUT_DATA_W - 1)'(0), r_verdict};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= 1'b0;
            r_mbusy     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output once taken
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // advance the multiplier, MSB of the multiplier operand first
            if (r_mbusy) begin
                if (!r_mph) begin
                    r_macc <= m_sum;
                    r_mph  <= 1'b1;
                end else begin
                    r_macc <= m_res;
                    r_my   <= r_my << 1;
                    r_mph  <= 1'b0;
                    r_mcnt <= r_mcnt + CW'(1);
                    if (m_last) begin
                        r_mbusy <= 1'b0;
                    end
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cand  <= cand_in;
                        r_wit   <= wit_in;
                        r_last  <= i_s_axis_tlast;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_cand == W'(2)) begin
                        r_comp  <= 1'b0;
                        r_state <= S_DONE;
                    end else if ((r_cand < W'(2)) || !r_cand[0]) begin
                        r_comp  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_exp   <= n_minus1;
                        r_s     <= '0;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    r_rem <= red_next;
                    r_wit <= r_wit << 1;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(W - 1)) begin
                        r_state <= S_FACTOR;
                    end
                end
                S_FACTOR: begin
                    if (!r_exp[0]) begin
                        r_exp <= r_exp >> 1;
                        r_s   <= r_s + CW'(1);
                    end else begin
                        r_acc   <= W'(1);
                        r_base  <= r_rem;
                        r_state <= S_POW;
                    end
                end
                S_POW: begin
                    r_mbusy <= 1'b1;
                    r_mph   <= 1'b0;
                    r_macc  <= '0;
                    r_mcnt  <= '0;
                    if (r_exp == '0) begin
                        r_mbusy <= 1'b0;
                        r_state <= S_TEST;
                    end else if (r_exp[0]) begin
                        r_mx    <= r_acc;
                        r_my    <= r_base;
                        r_state <= S_PMUL;
                    end else begin
                        r_mx    <= r_base;
                        r_my    <= r_base;
                        r_state <= S_PSQR;
                    end
                end
                S_PMUL: begin
                    if (m_last) begin
                        r_acc   <= m_res;
                        // start the base square straight away
                        r_mbusy <= 1'b1;
                        r_mph   <= 1'b0;
                        r_macc  <= '0;
                        r_mcnt  <= '0;
                        r_mx    <= r_base;
                        r_my    <= r_base;
                        r_state <= S_PSQR;
                    end
                end
                S_PSQR: begin
                    if (m_last) begin
                        r_base  <= m_res;
                        r_exp   <= r_exp >> 1;
                        r_state <= S_POW;
                    end
                end
                S_TEST: begin
                    if ((r_acc == W'(1)) || (r_acc == n_minus1)) begin
                        r_comp  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= CW'(1);
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt >= r_s) begin
                        r_comp  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_mbusy <= 1'b1;
                        r_mph   <= 1'b0;
                        r_macc  <= '0;
                        r_mcnt  <= '0;
                        r_mx    <= r_acc;
                        r_my    <= r_acc;
                        r_state <= S_SQW;
                    end
                end
                S_SQW: begin
                    if (m_last) begin
                        r_acc <= m_res;
                        if (m_res == n_minus1) begin
                            r_comp  <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_cnt   <= r_cnt + CW'(1);
                            r_state <= S_SQ;
                        end
                    end
                end
                S_DONE: begin
                    // hold until the output register can take the result
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_verdict   <= r_seen || r_comp;
                        r_run_done  <= r_last;
                        r_seen      <= r_last ? 1'b0 : (r_seen || r_comp);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // the multiplier only runs while the sequencer waits on it
    a_mul_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mbusy |-> (r_state == S_PMUL || r_state == S_PSQR || r_state == S_SQW))
        else $error("multiplier busy outside a multiply wait state");

    // an accepted item always starts with the trivial-candidate check
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_CHECK))
        else $error("accepted item did not enter the check state");

    // the partial remainder stays reduced throughout the witness reduction
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REDUCE) |-> (r_rem < r_cand))
        else $error("witness remainder left its range");

    // the run flag clears once the closing result is loaded
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free && r_last) |=> !r_seen)
        else $error("composite flag survived the end of a run");

    // a loaded result carries the run flag or this round's finding
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=>
            (r_out_valid && (r_verdict == ($past(r_seen) || $past(r_comp)))))
        else $error("result does not match the collected verdict");

endmodule
